// ===== hw/rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the min-heap priority queue core.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	// Width of one stored key.
	localparam int KEY_W = 32;

	// Command codes carried by a request item.
	typedef enum logic [0:0] {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	// Status codes carried by a result item.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef logic signed [KEY_W-1:0] key_t;

endpackage

// ===== hw/rtl/mhpq_if.sv =====
// ----------------------------------------------------------------------------
// mhpq_req_if / mhpq_rsp_if
// Valid/ready channels for request items and result items of the heap core.
// ----------------------------------------------------------------------------
interface mhpq_req_if;
	logic                 valid;
	logic                 ready;
	logic                 command;
	mhpq_pkg::key_t       key_in;

	modport source (output valid, output command, output key_in, input ready);
	modport sink   (input valid, input command, input key_in, output ready);
endinterface

interface mhpq_rsp_if #(
	parameter int CNT_W = 7
);
	logic                 valid;
	logic                 ready;
	mhpq_pkg::key_t       removed_key;
	logic [1:0]           status;
	logic [CNT_W-1:0]     entry_count_out;

	modport source (output valid, output removed_key, output status,
		output entry_count_out, input ready);
	modport sink   (input valid, input removed_key, input status,
		input entry_count_out, output ready);
endinterface

// ===== hw/rtl/min_heap_priority_queue_core.sv =====
// An accepted insert climbs through the read and compare steps until its key stops below a
// parent or reaches the root; a removal loads the root and the last key, then sinks the moved
// key through the read and compare steps until it stops or reaches a leaf. A refused command
// goes straight to the finish step. The core takes no new item until the result of the last
// one is loaded, so a stalled result holds it up.
// Reset (arst_n low) empties the heap at once; the key store is not cleared.
// ----------------------------------------------------------------------------
// min_heap_priority_queue_core
// Binary min-heap of signed keys held in one RAM; sifts with a hole register.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_core #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	mhpq_req_if.sink    req,
	mhpq_rsp_if.source  rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int EXT_W = IDX_W + 2;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_UP_RD   = 7'b0000010,
		S_UP_CMP  = 7'b0000100,
		S_DN_LOAD = 7'b0001000,
		S_DN_RD   = 7'b0010000,
		S_DN_CMP  = 7'b0100000,
		S_FINISH  = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       entry_count_q;
	logic [IDX_W-1:0]       pos_q;
	mhpq_pkg::key_t         key_q;
	mhpq_pkg::key_t         res_key_q;
	mhpq_pkg::status_t      res_status_q;

	logic                   rsp_valid_q;
	mhpq_pkg::key_t         rsp_key_q;
	mhpq_pkg::status_t      rsp_status_q;
	logic [CNT_W-1:0]       rsp_count_q;

	logic                   req_fire;
	logic                   rsp_free;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	mhpq_pkg::key_t         ram_wdata;
	logic [IDX_W-1:0]       ram_raddr_a;
	logic [IDX_W-1:0]       ram_raddr_b;
	logic [mhpq_pkg::KEY_W-1:0] ram_rdata_a;
	logic [mhpq_pkg::KEY_W-1:0] ram_rdata_b;

	logic [EXT_W-1:0]       left_x;
	logic [EXT_W-1:0]       right_x;
	logic [EXT_W-1:0]       count_x;
	logic [IDX_W-1:0]       parent_idx;
	logic                   left_in;
	logic                   right_in;
	logic                   pick_right;
	mhpq_pkg::key_t         pick_key;
	logic [IDX_W-1:0]       pick_idx;
	logic                   heap_full;
	logic                   heap_empty;

	assign req_fire   = req.valid && req.ready;
	assign req.ready  = (state_q == S_IDLE);
	assign rsp_free   = !rsp_valid_q || rsp.ready;
	assign heap_full  = (entry_count_q == CNT_W'(CAPACITY));
	assign heap_empty = (entry_count_q == '0);

	// Child and parent positions of the hole.
	assign left_x     = EXT_W'({pos_q, 1'b1});
	assign right_x    = left_x + EXT_W'(1);
	assign count_x    = EXT_W'(entry_count_q);
	assign parent_idx = IDX_W'((pos_q - IDX_W'(1)) >> 1);
	assign left_in    = left_x < count_x;
	assign right_in   = right_x < count_x;

	// Smaller child, left on a tie.
	assign pick_right = right_in && ($signed(ram_rdata_b) < $signed(ram_rdata_a));
	assign pick_key   = pick_right ? $signed(ram_rdata_b) : $signed(ram_rdata_a);
	assign pick_idx   = pick_right ? right_x[IDX_W-1:0] : left_x[IDX_W-1:0];

	// Read addresses per state.
	always_comb begin
		ram_raddr_a = '0;
		ram_raddr_b = '0;
		unique case (state_q)
			S_IDLE: begin
				ram_raddr_a = '0;
				ram_raddr_b = IDX_W'(entry_count_q - CNT_W'(1));
			end
			S_UP_RD: begin
				ram_raddr_a = parent_idx;
			end
			S_DN_RD: begin
				ram_raddr_a = left_x[IDX_W-1:0];
				ram_raddr_b = right_x[IDX_W-1:0];
			end
			default: begin
				ram_raddr_a = '0;
				ram_raddr_b = '0;
			end
		endcase
	end

	// Write-back of the hole: either the moving key or the displaced neighbor.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = key_q;
		unique case (state_q)
			S_UP_RD: begin
				ram_we = (pos_q == '0);
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (key_q < $signed(ram_rdata_a)) begin
					ram_wdata = $signed(ram_rdata_a);
				end
			end
			S_DN_RD: begin
				ram_we = !left_in;
			end
			S_DN_CMP: begin
				ram_we = 1'b1;
				if (pick_key < key_q) begin
					ram_wdata = pick_key;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (req.command == mhpq_pkg::CMD_INSERT) begin
							if (heap_full) begin
								state_q <= S_FINISH;
							end else begin
								entry_count_q <= entry_count_q + CNT_W'(1);
								state_q       <= S_UP_RD;
							end
						end else begin
							if (heap_empty) begin
								state_q <= S_FINISH;
							end else begin
								entry_count_q <= entry_count_q - CNT_W'(1);
								state_q       <= S_DN_LOAD;
							end
						end
					end
				end
				S_UP_RD: begin
					state_q <= (pos_q == '0) ? S_FINISH : S_UP_CMP;
				end
				S_UP_CMP: begin
					state_q <= (key_q < $signed(ram_rdata_a)) ? S_UP_RD : S_FINISH;
				end
				S_DN_LOAD: begin
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					state_q <= left_in ? S_DN_CMP : S_FINISH;
				end
				S_DN_CMP: begin
					state_q <= (pick_key < key_q) ? S_DN_RD : S_FINISH;
				end
				S_FINISH: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hole position, moving key and pending result fields.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					pos_q     <= IDX_W'(entry_count_q);
					key_q     <= req.key_in;
					res_key_q <= '0;
					if (req.command == mhpq_pkg::CMD_INSERT) begin
						res_status_q <= heap_full ? mhpq_pkg::ST_FULL : mhpq_pkg::ST_OK;
					end else begin
						res_status_q <= heap_empty ? mhpq_pkg::ST_EMPTY : mhpq_pkg::ST_OK;
					end
				end
			end
			S_UP_CMP: begin
				if (key_q < $signed(ram_rdata_a)) begin
					pos_q <= parent_idx;
				end
			end
			S_DN_LOAD: begin
				res_key_q <= $signed(ram_rdata_a);
				key_q     <= $signed(ram_rdata_b);
				pos_q     <= '0;
			end
			S_DN_CMP: begin
				if (pick_key < key_q) begin
					pos_q <= pick_idx;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && rsp_free) begin
			rsp_key_q    <= res_key_q;
			rsp_status_q <= res_status_q;
			rsp_count_q  <= entry_count_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.removed_key     = rsp_key_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.entry_count_out = rsp_count_q;

	mhpq_ram #(
		.WIDTH (mhpq_pkg::KEY_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	// The fill level never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// The fill level moves only when an item is taken.
	a_count_moves_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(entry_count_q != $past(entry_count_q)) |-> $past(req_fire))
		else $error("entry count changed without an accepted item");

	// A result appears only out of the finish step.
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !$past(rsp_valid_q)) |-> $past(state_q == S_FINISH))
		else $error("result loaded outside the finish step");

	// During a sift the hole stays inside the live part of the heap.
	a_hole_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_UP_RD || state_q == S_UP_CMP || state_q == S_DN_RD ||
		  state_q == S_DN_CMP) && entry_count_q != '0)
		|-> (CNT_W'(pos_q) < entry_count_q))
		else $error("sift position outside the heap");

endmodule

// ===== hw/rtl/mhpq_ram.sv =====
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== verif/min_heap_priority_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// min_heap_priority_queue_core_tb
// Self-checking bench for the min-heap core. A scoreboard class keeps its own
// heap of signed keys and works out the result of every accepted request
// item. Each result item is checked in order against that prediction. The
// stimulus starts with directed extremes, ties and refused commands. It then
// runs random fill, drain and mixed stretches under three idling patterns.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_core_tb;
	import mhpq_pkg::*;

	localparam int HEAP_DEPTH = 64;
	localparam int CNT_W      = 7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		key_t             removed;
		status_t          status;
		logic [CNT_W-1:0] count;
	} heap_result_t;

	// Predicts the heap core and checks its result items in order.
	class heap_scoreboard;
		key_t           slots[HEAP_DEPTH];
		int unsigned    held;
		heap_result_t   expected_q[$];
		int unsigned    n_requests;
		int unsigned    n_results;
		int unsigned    n_removed;
		int unsigned    n_full;
		int unsigned    n_empty;
		int unsigned    peak_held;
		int unsigned    fail_count;

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			fail_count++;
		endtask

		// Applies one accepted request to the local heap and queues its result.
		function void note_request(cmd_t cmd, key_t key);
			heap_result_t r;
			int           pos;
			int           up;
			int           left;
			int           pick;
			key_t         tmp;
			r.removed = '0;
			r.status  = ST_OK;
			n_requests++;
			if (cmd == CMD_INSERT) begin
				if (held >= HEAP_DEPTH) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					// Place at the end and climb while strictly smaller.
					slots[held] = key;
					pos = held;
					held++;
					while (pos > 0) begin
						up = (pos - 1) / 2;
						if (!(slots[pos] < slots[up]))
							break;
						tmp = slots[pos];
						slots[pos] = slots[up];
						slots[up] = tmp;
						pos = up;
					end
				end
			end else begin
				if (held == 0) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					// Take the root, move the last key up and sink it.
					r.removed = slots[0];
					n_removed++;
					held--;
					slots[0] = slots[held];
					pos = 0;
					forever begin
						left = 2 * pos + 1;
						if (left >= held)
							break;
						pick = left;
						if (left + 1 < held && slots[left + 1] < slots[left])
							pick = left + 1;
						if (!(slots[pick] < slots[pos]))
							break;
						tmp = slots[pos];
						slots[pos] = slots[pick];
						slots[pick] = tmp;
						pos = pick;
					end
				end
			end
			if (held > peak_held)
				peak_held = held;
			r.count = held[CNT_W-1:0];
			expected_q.push_back(r);
		endfunction

		// Compares one result item with the oldest prediction.
		task check_result(key_t removed, logic [1:0] status, logic [CNT_W-1:0] count);
			heap_result_t e;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result with no request pending (key %0d status %0d)",
					removed, status));
				return;
			end
			e = expected_q.pop_front();
			n_results++;
			if (removed !== e.removed)
				report_mismatch($sformatf("result %0d: removed_key %0d, predicted %0d",
					n_results, removed, e.removed));
			if (status !== e.status)
				report_mismatch($sformatf("result %0d: status %0d, predicted %0d",
					n_results, status, e.status));
			if (count !== e.count)
				report_mismatch($sformatf("result %0d: entry_count_out %0d, predicted %0d",
					n_results, count, e.count));
		endtask

		task flag_missing();
			while (expected_q.size() != 0) begin
				void'(expected_q.pop_front());
				report_mismatch("predicted result never arrived");
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;

	mhpq_req_if                  req_ch ();
	mhpq_rsp_if #(.CNT_W(CNT_W)) rsp_ch ();

	heap_scoreboard sb = new();

	min_heap_priority_queue_core #(
		.CAPACITY(HEAP_DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop if the run hangs.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles with %0d results pending", CYCLE_LIMIT,
			sb.expected_q.size());
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: sample at the rising edge, change ready at the falling edge.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				sb.check_result(rsp_ch.removed_key, rsp_ch.status, rsp_ch.entry_count_out);
			@(negedge clk);
			rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Half fully random keys; the rest give plenty of ties, small negatives and keys near both extremes.
	function automatic key_t pick_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return key_t'($urandom);
			5, 6:          return key_t'(int'($urandom_range(0, 8)) - 4);
			7:             return key_t'(32'h7FFF_FFFF - $urandom_range(0, 2));
			8:             return key_t'(32'h8000_0000 + $urandom_range(0, 2));
			default:       return key_t'(-int'($urandom_range(1, 1000)));
		endcase
	endfunction

	// Presents one request item, starting and ending at a falling edge.
	task send_item(cmd_t cmd, key_t key);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid   = 1'b1;
		req_ch.command = cmd;
		req_ch.key_in  = key;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		sb.note_request(cmd, key);
		@(negedge clk);
	endtask

	// One idling pattern: fill past full, drain past empty, then mixed stretches.
	task run_phase(int unsigned target);
		int unsigned start;
		int unsigned ins_pct;
		start = sb.n_requests;
		while (sb.held < HEAP_DEPTH)
			send_item(CMD_INSERT, pick_key());
		repeat ($urandom_range(1, 3))
			send_item(CMD_INSERT, pick_key());
		while (sb.held > 0)
			send_item(CMD_REMOVE, key_t'($urandom));
		repeat ($urandom_range(1, 2))
			send_item(CMD_REMOVE, key_t'($urandom));
		while (sb.n_requests - start < target) begin
			ins_pct = $urandom_range(15, 85);
			repeat ($urandom_range(10, 60))
				send_item(($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE,
					pick_key());
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.command = CMD_INSERT;
		req_ch.key_in  = '0;
		send_idle_pct  = 19;
		recv_idle_pct  = 57;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty removal, extremes, ties and an ignored key on removal.
		send_item(CMD_REMOVE, key_t'(32'h1234_5678));
		send_item(CMD_INSERT, key_t'(0));
		send_item(CMD_INSERT, key_t'(32'h7FFF_FFFF));
		send_item(CMD_INSERT, key_t'(32'h8000_0000));
		send_item(CMD_INSERT, key_t'(-1));
		send_item(CMD_INSERT, key_t'(1));
		send_item(CMD_INSERT, key_t'(0));
		send_item(CMD_INSERT, key_t'(-1));
		send_item(CMD_INSERT, key_t'(32'h8000_0000));
		send_item(CMD_INSERT, key_t'(32'hAAAA_AAAA));
		send_item(CMD_INSERT, key_t'(32'h5555_5555));
		repeat (10)
			send_item(CMD_REMOVE, key_t'(32'hFFFF_FFFF));
		send_item(CMD_REMOVE, key_t'(32'h8000_0001));

		// Random part under three idling patterns.
		run_phase(330);
		send_idle_pct = 57;
		recv_idle_pct = 19;
		run_phase(330);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(340);
		req_ch.valid = 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.flag_missing();

		$display("Run covered %0d requests and %0d results: %0d keys removed, peak fill %0d of %0d.",
			sb.n_requests, sb.n_results, sb.n_removed, sb.peak_held, HEAP_DEPTH);
		$display("Refused inserts on a full heap: %0d, refused removals on an empty heap: %0d.",
			sb.n_full, sb.n_empty);
		if (sb.fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", sb.fail_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_if.sv
hw/rtl/mhpq_ram.sv
hw/rtl/min_heap_priority_queue_core.sv
verif/min_heap_priority_queue_core_tb.sv
